FILE: rtl/core/clun_pkg.sv
`timescale 1ns / 1ps

package clun_pkg;

  localparam int NUM_UNITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int UNIT_W   = 4;
  localparam int WORD_W   = 32;
  localparam int DT_W     = 25;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W   = 24;

  localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_LEAK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP        = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESERVED    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE        = 2'd3;

  localparam logic [DT_W-1:0] TIME_STEP_RST = 25'd16777;

  // The square root operand is the 57-bit product of diffusion and time
  // step, padded to an even width and consumed two bits per iteration.
  localparam int SQ_OP_W   = 58;
  localparam int SQ_STEPS  = SQ_OP_W / 2;
  localparam int SQ_ROOT_W = SQ_STEPS;
  localparam int SQ_REM_W  = 32;
  localparam int SQ_CNT_W  = 5;

endpackage

FILE: rtl/core/coupled_leaky_unit_network_step.sv
`timescale 1ns / 1ps

// Steps a network of NUM_UNITS leaky noisy units in signed Q8.24. A load
// transaction (weight or leak factor) leaves the input ready and produces no
// result. A step transaction keeps the input busy until its result enters the
// output register, which waits while an earlier result there is not yet taken:
// the 29-iteration square root of diffusion times time step runs beside the
// coupling sum, which reads one level and one weight per cycle from the
// memories. Unit levels live in a two-slot level memory with a slot select
// bit per unit, so the end-of-tick swap is only a flip of those bits. A new
// transaction is accepted while a result still waits on the output register.
module coupled_leaky_unit_network_step
  import clun_pkg::*;
#(
  parameter int NUM_UNITS = NUM_UNITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [DT_W-1:0]             cfg_data,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [CMD_W-1:0]            cmd,
  input  logic [UNIT_W-1:0]           row_unit,
  input  logic [UNIT_W-1:0]           col_unit,
  input  logic signed [WORD_W-1:0]    load_value,
  input  logic [WORD_W-1:0]           diffusion_level,
  input  logic signed [WORD_W-1:0]    noise_sample,
  input  logic                        end_of_tick,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [UNIT_W-1:0]           unit_index,
  output logic signed [WORD_W-1:0]    new_level,
  output logic                        tick_done,
  output logic                        saturated
);

  localparam int IW     = $clog2(NUM_UNITS);
  localparam int ACC_W  = 40 + IW;
  localparam int TA_W   = ACC_W + 14;
  localparam int TB_W   = ACC_W + 13;
  localparam int BASE_W = 41;
  localparam int PART_W = 42;
  localparam int TOT_W  = ACC_W + 4;
  localparam logic [IW:0] CNT_N = (IW + 1)'(NUM_UNITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LEAK = 6'b000010,
    S_MAC  = 6'b000100,
    S_DT   = 6'b001000,
    S_SUM  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;

  logic [DT_W-1:0] time_step;
  logic            coupling_en;

  logic signed [WORD_W-1:0] lvl_mem [2*NUM_UNITS];
  logic signed [WORD_W-1:0] wgt_mem [NUM_UNITS << IW];
  logic signed [WORD_W-1:0] leak_mem [NUM_UNITS];
  logic [2*NUM_UNITS-1:0]   lvl_vld;
  logic [NUM_UNITS-1:0]     bank;
  logic [NUM_UNITS-1:0]     pending;

  logic [IW:0]              lvl_raddr;
  logic [2*IW-1:0]          wgt_raddr;
  logic signed [WORD_W-1:0] lvl_rd;
  logic                     lvl_ok;
  logic signed [WORD_W-1:0] wgt_rd;
  logic signed [WORD_W-1:0] leak_rd;
  logic signed [WORD_W-1:0] lvl_val;

  logic [UNIT_W-1:0]        row_raw;
  logic [IW-1:0]            row_idx;
  logic [IW-1:0]            in_idx;
  logic [IW-1:0]            col_idx;
  logic                     row_ok;
  logic                     col_ok;
  logic signed [WORD_W-1:0] noise_reg;
  logic                     eot_reg;

  logic [IW:0]              cnt;
  logic [IW-1:0]            jdx;
  logic                     issue;
  logic                     rd_v;
  logic                     pr_v;

  logic signed [WORD_W-1:0] x_reg;
  logic signed [63:0]       leak_prod;
  logic signed [63:0]       wx_prod;
  logic signed [39:0]       leak_t;
  logic signed [39:0]       wx_t;
  logic signed [ACC_W-1:0]  acc;
  logic signed [BASE_W-1:0] base;
  logic signed [TA_W-1:0]   ta;
  logic signed [TB_W-1:0]   tb;
  logic signed [TA_W:0]     tsum;
  logic signed [61:0]       noise_prod;
  logic signed [37:0]       noise_t;
  logic signed [ACC_W+2:0]  term;
  logic signed [PART_W-1:0] part;
  logic signed [TOT_W-1:0]  total;
  logic signed [WORD_W-1:0] total_sat;
  logic                     sat_c;
  logic                     fin_go;

  logic [SQ_OP_W-1:0]       sq_op;
  logic [SQ_REM_W-1:0]      sq_rem;
  logic [SQ_ROOT_W-1:0]     sq_root;
  logic [SQ_CNT_W-1:0]      sq_cnt;
  logic [SQ_REM_W+1:0]      rem_sh;
  logic [SQ_REM_W+1:0]      trial;
  logic [SQ_OP_W-2:0]       dd_c;

  logic item_fire;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign item_fire  = item_valid && item_ready;

  assign in_idx  = IW'(row_unit);
  assign col_idx = IW'(col_unit);
  assign row_ok  = (32'(row_unit) < NUM_UNITS);
  assign col_ok  = (32'(col_unit) < NUM_UNITS);
  assign row_idx = IW'(row_raw);
  assign jdx     = cnt[IW-1:0];
  assign issue   = ((state == S_LEAK) || (state == S_MAC)) && (cnt < CNT_N);

  always_comb begin
    if (state == S_IDLE) begin
      lvl_raddr = {in_idx, bank[in_idx]};
    end else begin
      lvl_raddr = {jdx, bank[jdx]};
    end
  end
  assign wgt_raddr = {row_idx, jdx};
  assign lvl_val   = lvl_ok ? lvl_rd : '0;

  assign leak_t  = leak_prod[63:24];
  assign wx_t    = wx_prod[63:24];
  assign noise_t = noise_prod[61:24];
  assign tsum    = (TA_W + 1)'(ta) + (TA_W + 1)'($signed(tb[TB_W-1:12]));
  assign total   = TOT_W'(part) + (coupling_en ? TOT_W'(term) : '0);
  assign dd_c    = diffusion_level * time_step;

  always_comb begin
    sat_c = 1'b1;
    if (total > TOT_W'(64'sh7FFF_FFFF)) begin
      total_sat = 32'sh7FFF_FFFF;
    end else if (total < -TOT_W'(64'sh8000_0000)) begin
      total_sat = 32'sh8000_0000;
    end else begin
      total_sat = total[WORD_W-1:0];
      sat_c     = 1'b0;
    end
  end

  assign fin_go = (state == S_FIN) && (!result_valid || result_ready);

  assign rem_sh = {sq_rem, sq_op[SQ_OP_W-1 -: 2]};
  assign trial  = (SQ_REM_W + 2)'({sq_root, 2'b01});

  always_ff @(posedge clk) begin
    lvl_rd  <= lvl_mem[lvl_raddr];
    wgt_rd  <= wgt_mem[wgt_raddr];
    leak_rd <= leak_mem[in_idx];
    if (fin_go) begin
      lvl_mem[{row_idx, ~bank[row_idx]}] <= total_sat;
    end
    if (item_fire && (cmd == CMD_LOAD_WEIGHT) && row_ok && col_ok) begin
      wgt_mem[{in_idx, col_idx}] <= load_value;
    end
    if (item_fire && (cmd == CMD_LOAD_LEAK) && row_ok) begin
      leak_mem[in_idx] <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step   <= TIME_STEP_RST;
      coupling_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TIME_STEP) begin
        time_step <= cfg_data;
      end else if (cfg_index == REG_COUPLING_EN) begin
        coupling_en <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (item_fire && (cmd == CMD_STEP) && row_ok) begin
      sq_cnt <= SQ_CNT_W'(SQ_STEPS);
    end else if (sq_cnt != '0) begin
      sq_cnt <= sq_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      sq_op   <= {1'b0, dd_c};
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (sq_cnt != '0) begin
      sq_op <= {sq_op[SQ_OP_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        sq_rem  <= SQ_REM_W'(rem_sh - trial);
        sq_root <= {sq_root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem  <= SQ_REM_W'(rem_sh);
        sq_root <= {sq_root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_ok <= lvl_vld[lvl_raddr];
    if (item_fire) begin
      row_raw   <= row_unit;
      noise_reg <= noise_sample;
      eot_reg   <= end_of_tick;
    end
    if (state == S_LEAK) begin
      x_reg     <= lvl_val;
      leak_prod <= lvl_val * leak_rd;
    end
    wx_prod <= wgt_rd * lvl_val;
    base    <= BASE_W'(x_reg) - BASE_W'(leak_t);
    if (state == S_DT) begin
      ta         <= acc * $signed({1'b0, time_step[DT_W-1:12]});
      tb         <= acc * $signed({1'b0, time_step[11:0]});
      noise_prod <= $signed({1'b0, sq_root}) * noise_reg;
    end
    if (state == S_SUM) begin
      term <= tsum[TA_W:12];
      part <= PART_W'(base) + PART_W'(noise_t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      rd_v         <= 1'b0;
      pr_v         <= 1'b0;
      acc          <= '0;
      lvl_vld      <= '0;
      bank         <= '0;
      pending      <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_v <= issue;
      pr_v <= rd_v;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (pr_v) begin
        acc <= acc + ACC_W'(wx_t);
      end
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_fire && (cmd == CMD_STEP) && row_ok) begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_LEAK;
          end
        end
        S_LEAK: begin
          state <= S_MAC;
        end
        S_MAC: begin
          if ((cnt == CNT_N) && !rd_v && !pr_v) begin
            state <= S_DT;
          end
        end
        S_DT: begin
          if (sq_cnt == '0) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            result_valid                  <= 1'b1;
            lvl_vld[{row_idx, ~bank[row_idx]}] <= 1'b1;
            if (eot_reg) begin
              for (int u = 0; u < NUM_UNITS; u++) begin
                if (pending[u] || (IW'(u) == row_idx)) begin
                  bank[u] <= ~bank[u];
                end
              end
              pending <= '0;
            end else begin
              pending[row_idx] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      unit_index <= row_raw;
      new_level  <= total_sat;
      tick_done  <= eot_reg;
      saturated  <= sat_c;
    end
  end

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sq_cnt == '0))
    else $error("square root still running while idle");

  a_swap_clears: assert property (@(posedge clk) disable iff (rst)
    (fin_go && eot_reg) |=> (pending == '0))
    else $error("pending units left after end of tick");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FIN))
    else $error("result raised outside of final state");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_N)
    else $error("coupling read counter out of range");

endmodule
